### rtl/hsfp_pkg.sv
// shared types and constants of the horizontal span fill planner
package hsfp_pkg;

    localparam logic       OP_MASKED = 1'b0;
    localparam logic       OP_RUN    = 1'b1;
    localparam logic [7:0] FULL_MASK = 8'hFF;

    localparam logic       REG_BITMAP_BASE = 1'b0;
    localparam logic       REG_ROW_STRIDE  = 1'b1;

    localparam logic [15:0] BASE_RESET   = 16'd0;
    localparam logic [7:0]  STRIDE_RESET = 8'd80;

    typedef struct packed {
        logic [10:0] start_x;
        logic [9:0]  row_y;
        logic [10:0] span_length;
        logic        pixel_color;
    } item_t;

    // one classified line, up to three operations
    typedef struct packed {
        logic [15:0] row_addr;
        logic        color;
        logic        has_first;
        logic [7:0]  first_mask;
        logic [8:0]  first_off;
        logic        has_run;
        logic [8:0]  run_off;
        logic [8:0]  run_count;
        logic        has_last;
        logic [7:0]  last_mask;
        logic [8:0]  last_off;
    } desc_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  mask;
        logic        color;
        logic [8:0]  count;
        logic        last;
    } op_t;

endpackage

### rtl/hsfp_front.sv
// front end: holds an accepted line and classifies it into a descriptor
module hsfp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  hsfp_pkg::item_t    item,
    output logic               busy,
    input  logic [15:0]        bitmap_base,
    input  logic [7:0]         row_stride,
    input  logic               q_full,
    output logic               push,
    output hsfp_pkg::desc_t    push_desc
);
    import hsfp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    item_t       item_reg;
    logic        zero_len;
    logic        advance;
    logic [11:0] last_px;
    logic [7:0]  fb;
    logic [2:0]  fx;
    logic [8:0]  lb;
    logic [2:0]  lx;
    logic [7:0]  mask_hi;
    logic [7:0]  mask_lo;
    logic        single;
    logic [8:0]  full_start;
    logic [9:0]  full_end;
    logic [17:0] row_prod;
    logic [9:0]  run_diff;

    assign zero_len = (item_reg.span_length == 11'd0);
    assign advance  = !valid_reg || zero_len || !q_full;
    assign busy     = !advance;
    assign push     = valid_reg && !zero_len && !q_full;

    assign valid_next = (start && !busy) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        last_px    = {1'b0, item_reg.start_x} + {1'b0, item_reg.span_length} - 12'd1;
        fb         = item_reg.start_x[10:3];
        fx         = item_reg.start_x[2:0];
        lb         = last_px[11:3];
        lx         = last_px[2:0];
        mask_hi    = FULL_MASK >> fx;
        mask_lo    = FULL_MASK << (3'd7 - lx);
        single     = ({1'b0, fb} == lb);
        full_start = {1'b0, fb} + {8'd0, (fx != 3'd0)};
        full_end   = {1'b0, lb} + {9'd0, (lx == 3'd7)};
        run_diff   = full_end - {1'b0, full_start};
        row_prod   = {8'd0, item_reg.row_y} * {10'd0, row_stride};

        push_desc.row_addr   = bitmap_base + row_prod[15:0];
        push_desc.color      = item_reg.pixel_color;
        push_desc.first_off  = {1'b0, fb};
        push_desc.run_off    = full_start;
        push_desc.run_count  = run_diff[8:0];
        push_desc.last_mask  = mask_lo;
        push_desc.last_off   = lb;
        if (single)
        begin
            push_desc.has_first  = 1'b1;
            push_desc.first_mask = mask_hi & mask_lo;
            push_desc.has_run    = 1'b0;
            push_desc.has_last   = 1'b0;
        end
        else
        begin
            push_desc.has_first  = (fx != 3'd0);
            push_desc.first_mask = mask_hi;
            push_desc.has_run    = (full_end > {1'b0, full_start});
            push_desc.has_last   = (lx != 3'd7);
        end
    end

endmodule

### rtl/hsfp_queue.sv
// short descriptor queue between front and back end
module hsfp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hsfp_pkg::desc_t    push_desc,
    output logic               full,
    input  logic               pop,
    output hsfp_pkg::desc_t    pop_desc,
    output logic               empty
);
    import hsfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    desc_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_desc = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

### rtl/hsfp_back.sv
// back end: steps through a descriptor, one operation per cycle
module hsfp_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  hsfp_pkg::desc_t    q_desc,
    output logic               pop,
    output logic               op_valid,
    output hsfp_pkg::op_t      op
);
    import hsfp_pkg::*;

    desc_t       desc_reg;
    logic [2:0]  pend_reg;
    logic [2:0]  pend_next;
    logic [2:0]  pend_left;
    logic        active;
    op_t         op_next;
    op_t         op_reg;
    logic        valid_reg;
    logic [8:0]  off;

    assign active = (pend_reg != 3'b000);

    always_comb
    begin
        pend_left      = pend_reg;
        off            = desc_reg.first_off;
        op_next.kind   = OP_MASKED;
        op_next.mask   = desc_reg.first_mask;
        op_next.count  = 9'd1;
        priority if (pend_reg[0])
        begin
            pend_left[0] = 1'b0;
        end
        else if (pend_reg[1])
        begin
            pend_left[1]  = 1'b0;
            off           = desc_reg.run_off;
            op_next.kind  = OP_RUN;
            op_next.mask  = FULL_MASK;
            op_next.count = desc_reg.run_count;
        end
        else
        begin
            pend_left[2] = 1'b0;
            off          = desc_reg.last_off;
            op_next.mask = desc_reg.last_mask;
        end
        op_next.addr  = desc_reg.row_addr + {7'd0, off};
        op_next.color = desc_reg.color;
        op_next.last  = (pend_left == 3'b000);

        pop       = !q_empty && (pend_left == 3'b000);
        pend_next = pop ? {q_desc.has_last, q_desc.has_run, q_desc.has_first} : pend_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 3'b000;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= q_desc;
        end
        op_reg <= op_next;
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

### rtl/horizontal_span_fill_planner_core.sv
// top level of the horizontal span fill planner with its register port
// latency: a line passes the front item register, a queue slot, the back descriptor register and the operation register
// throughput: one operation per cycle from the back end, up to three operations a line
// the descriptor queue lets the front take new lines while the back is still emitting
// reset: async active low, clears control state, base 0 and stride 80
// results cannot be stalled, result_valid marks each one-cycle beat
module horizontal_span_fill_planner_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // line request
    input  logic        start,
    output logic        busy,
    input  logic [10:0] start_x,
    input  logic [9:0]  row_y,
    input  logic [10:0] span_length,
    input  logic        pixel_color,
    // operation beats
    output logic        result_valid,
    output logic        op_kind,
    output logic [15:0] byte_address,
    output logic [7:0]  bit_mask,
    output logic        fill_value,
    output logic [8:0]  run_count,
    output logic        last_op,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hsfp_pkg::*;

    logic [15:0] base_reg;
    logic [7:0]  stride_reg;
    logic        reg_wr;
    logic        reg_sel;
    item_t       item;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    desc_t       push_desc;
    desc_t       pop_desc;
    op_t         op;

    // register file, word aligned, one register per word
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            stride_reg <= STRIDE_RESET;
        end
        else if (reg_wr)
        begin
            unique case (reg_sel)
                REG_BITMAP_BASE: base_reg   <= pwdata[15:0];
                REG_ROW_STRIDE:  stride_reg <= pwdata[7:0];
                default:         base_reg   <= base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BITMAP_BASE: prdata = {16'd0, base_reg};
            REG_ROW_STRIDE:  prdata = {24'd0, stride_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign item.start_x     = start_x;
    assign item.row_y       = row_y;
    assign item.span_length = span_length;
    assign item.pixel_color = pixel_color;

    // front: holds one line, computes row address and splits it into first/run/last
    hsfp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .bitmap_base (base_reg),
        .row_stride  (stride_reg),
        .q_full      (q_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    // queue decouples classification from emission
    hsfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .empty     (q_empty)
    );

    // back: one registered operation beat per cycle, final beat flagged
    hsfp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_desc   (pop_desc),
        .pop      (pop),
        .op_valid (result_valid),
        .op       (op)
    );

    assign op_kind      = op.kind;
    assign byte_address = op.addr;
    assign bit_mask     = op.mask;
    assign fill_value   = op.color;
    assign run_count    = op.count;
    assign last_op      = op.last;

endmodule
